/* rtl/assert_macros.svh */
// Assertion macros for the checker file (tifec_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error("assertion failed");

// Implication checked in the following cycle.
`define ASSERT_NEXT(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

/* rtl/tifec_pkg.sv */
`timescale 1ns / 1ps
package tifec_pkg;

    localparam int MEM_BYTES_DEF = 131072;
    localparam int NUM_REGS_DEF  = 22;
    localparam int PC_INDEX      = 16;
    localparam int INSTR_BYTES   = 8;

    // item kinds
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TRAP    = 3'd1;
    localparam logic [2:0] ST_FETCH   = 3'd2;
    localparam logic [2:0] ST_BADOP   = 3'd3;
    localparam logic [2:0] ST_DIVZERO = 3'd4;
    localparam logic [2:0] ST_BADADDR = 3'd5;
    localparam logic [2:0] ST_HALTED  = 3'd6;

    // opcodes
    localparam logic [7:0] OPC_MOV  = 8'd7;
    localparam logic [7:0] OPC_MOVI = 8'd8;
    localparam logic [7:0] OPC_LDA  = 8'd9;
    localparam logic [7:0] OPC_STR  = 8'd10;
    localparam logic [7:0] OPC_LDR  = 8'd11;
    localparam logic [7:0] OPC_STB  = 8'd12;
    localparam logic [7:0] OPC_LDB  = 8'd13;
    localparam logic [7:0] OPC_ADD  = 8'd18;
    localparam logic [7:0] OPC_ADDI = 8'd19;
    localparam logic [7:0] OPC_SUB  = 8'd20;
    localparam logic [7:0] OPC_SUBI = 8'd21;
    localparam logic [7:0] OPC_MUL  = 8'd22;
    localparam logic [7:0] OPC_MULI = 8'd23;
    localparam logic [7:0] OPC_DIV  = 8'd24;
    localparam logic [7:0] OPC_SDIV = 8'd25;
    localparam logic [7:0] OPC_DIVI = 8'd26;
    localparam logic [7:0] OPC_TRP  = 8'd31;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_RREAD,
        S_EXEC,
        S_DIV,
        S_LOAD,
        S_STORE,
        S_WB,
        S_DONE
    } state_t;

    function automatic logic opc_known(input logic [7:0] opc);
        unique case (opc)
            OPC_MOV, OPC_MOVI, OPC_LDA, OPC_STR, OPC_LDR, OPC_STB, OPC_LDB,
            OPC_ADD, OPC_ADDI, OPC_SUB, OPC_SUBI, OPC_MUL, OPC_MULI,
            OPC_DIV, OPC_SDIV, OPC_DIVI, OPC_TRP: opc_known = 1'b1;
            default: opc_known = 1'b0;
        endcase
    endfunction

    // number of register operands an opcode uses
    function automatic logic [1:0] opc_nregs(input logic [7:0] opc);
        unique case (opc)
            OPC_MOVI, OPC_LDA, OPC_STR, OPC_LDR, OPC_STB, OPC_LDB: opc_nregs = 2'd1;
            OPC_MOV, OPC_ADDI, OPC_SUBI, OPC_MULI, OPC_DIVI:       opc_nregs = 2'd2;
            OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_SDIV:          opc_nregs = 2'd3;
            default:                                               opc_nregs = 2'd0;
        endcase
    endfunction

endpackage

/* rtl/tiny_isa_fetch_execute_core.sv */
`timescale 1ns / 1ps
// Sequence: write, start, halted and fetch-range items go straight to the result. A step
// fetches its 8-byte instruction and decodes it (a bad opcode or register ends there), reads
// 3 registers, executes (traps and execute faults end there), then divides, loads or stores
// and writes back (stores skip write-back). One item in flight; next transfer accepted the
// cycle after the result is registered, which waits until m_axis_tready frees the output.
// Reset: registers read zero (per-entry valid bits), core halted, entry_pc zero.
module tiny_isa_fetch_execute_core
    import tifec_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    parameter int NUM_REGS  = NUM_REGS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [16:0] mem_address, [24:17] mem_byte, rest zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] op
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // [31:0] pc_value, [32] reg_written,
                                       // [37:33] reg_index, [69:38] reg_value, rest zero
    output logic [2:0]  m_axis_tuser,  // [2:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW  = $clog2(MEM_BYTES);
    localparam int RIW = $clog2(NUM_REGS);

    // storage: byte memory and register file, both synchronous
    logic [7:0]  mem [MEM_BYTES];
    logic [31:0] rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_vld_reg;

    state_t state_reg, state_next;
    logic [5:0]  cnt_reg;
    logic [31:0] pc_reg;
    logic        halted_reg;
    logic [16:0] entry_pc_reg;
    logic [63:0] ins_reg;
    logic [1:0]  nregs_reg;
    logic [31:0] a_reg, b_reg, s_reg, res_reg;
    logic        wr_reg;
    logic [2:0]  status_reg;
    logic        m_valid_reg;
    logic [71:0] m_data_reg;
    logic [2:0]  m_user_reg;
    logic [7:0]  mem_rdata_reg;
    logic [31:0] rf_rdata_reg;
    logic [RIW-1:0] rf_ridx_reg;
    logic        rf_rpc_reg;
    // divider
    logic [31:0] dq_reg, dd_reg;
    logic [32:0] drem_reg;
    logic        dneg_reg;

    // combinational
    logic        s_hs, m_hs, cfg_wr, out_free;
    logic [1:0]  in_op;
    logic [16:0] in_addr;
    logic [7:0]  in_byte;
    logic        pc_fits, wr_item_ok;
    logic [7:0]  opc, r1, r2, r3;
    logic [31:0] imm, rd_val;
    logic        regs_bad, word_bad, byte_bad;
    logic [2:0]  nbytes;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic [7:0]  mem_wdata;
    logic        mem_we;
    logic [RIW-1:0] rf_raddr;
    logic [7:0]  rf_rsel;
    logic [31:0] abs_a, abs_d, dvs, exec_val, wb_val;
    logic [32:0] rem_sh;
    logic        ge;
    logic        is_div, is_div_exec, div_zero;

    assign s_hs     = s_axis_tvalid && s_axis_tready;
    assign m_hs     = m_valid_reg && m_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_op    = s_axis_tuser;
    assign in_addr  = s_axis_tdata[16:0];
    assign in_byte  = s_axis_tdata[24:17];

    assign pc_fits    = ({1'b0, pc_reg} + 33'(INSTR_BYTES)) <= 33'(MEM_BYTES);
    assign wr_item_ok = 25'(in_addr) < 25'(MEM_BYTES);

    assign opc = ins_reg[7:0];
    assign r1  = ins_reg[15:8];
    assign r2  = ins_reg[23:16];
    assign r3  = ins_reg[31:24];
    assign imm = ins_reg[63:32];

    // operand count comes straight from the opcode: checked in the decode cycle
    assign regs_bad = (opc_nregs(opc) >= 2'd1 && r1 >= 8'(NUM_REGS))
                   || (opc_nregs(opc) >= 2'd2 && r2 >= 8'(NUM_REGS))
                   || (opc_nregs(opc) == 2'd3 && r3 >= 8'(NUM_REGS));
    assign word_bad = ({1'b0, imm} + 33'd4) > 33'(MEM_BYTES);
    assign byte_bad = {1'b0, imm} >= 33'(MEM_BYTES);
    assign nbytes   = (opc == OPC_LDR || opc == OPC_STR) ? 3'd4 : 3'd1;

    // register read value: PC lives in its own register, unwritten entries read zero
    assign rd_val = rf_rpc_reg ? pc_reg
                  : (rf_vld_reg[rf_ridx_reg] ? rf_rdata_reg : 32'd0);

    // division operands
    assign is_div      = opc == OPC_DIV || opc == OPC_SDIV || opc == OPC_DIVI;
    assign dvs         = (opc == OPC_DIVI) ? imm : b_reg;
    assign is_div_exec = opc != OPC_DIV;
    assign abs_a       = (is_div_exec && a_reg[31]) ? (32'd0 - a_reg) : a_reg;
    assign abs_d       = (is_div_exec && dvs[31]) ? (32'd0 - dvs) : dvs;
    assign div_zero    = dvs == 32'd0;
    assign rem_sh      = {drem_reg[31:0], dq_reg[31]};
    assign ge          = rem_sh >= {1'b0, dd_reg};

    always_comb
    begin
        unique case (opc)
            OPC_MOV:                   exec_val = a_reg;
            OPC_ADD:                   exec_val = a_reg + b_reg;
            OPC_ADDI:                  exec_val = a_reg + imm;
            OPC_SUB:                   exec_val = a_reg - b_reg;
            OPC_SUBI:                  exec_val = a_reg - imm;
            OPC_MUL:                   exec_val = a_reg * b_reg;
            OPC_MULI:                  exec_val = a_reg * imm;
            default:                   exec_val = imm;   // MOVI, LDA
        endcase
    end

    assign wb_val = !is_div ? res_reg : (dneg_reg ? (32'd0 - dq_reg) : dq_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_hs)
                    state_next = (in_op == OP_STEP && !halted_reg && pc_fits) ? S_FETCH : S_DONE;
            S_FETCH:
                if (cnt_reg == 6'(INSTR_BYTES)) state_next = S_DECODE;
            S_DECODE:
                state_next = (!opc_known(opc) || regs_bad) ? S_DONE : S_RREAD;
            S_RREAD:
                if (cnt_reg == 6'd3) state_next = S_EXEC;
            S_EXEC:
            begin
                priority if (opc == OPC_TRP)
                    state_next = S_DONE;
                else if (is_div)
                    state_next = div_zero ? S_DONE : S_DIV;
                else if (opc == OPC_LDR)
                    state_next = word_bad ? S_DONE : S_LOAD;
                else if (opc == OPC_LDB)
                    state_next = byte_bad ? S_DONE : S_LOAD;
                else if (opc == OPC_STR)
                    state_next = word_bad ? S_DONE : S_STORE;
                else if (opc == OPC_STB)
                    state_next = byte_bad ? S_DONE : S_STORE;
                else
                    state_next = S_WB;
            end
            S_DIV:
                if (cnt_reg == 6'd31) state_next = S_WB;
            S_LOAD:
                if (cnt_reg == 6'(nbytes)) state_next = S_WB;
            S_STORE:
                if (cnt_reg == 6'(nbytes) - 6'd1) state_next = S_DONE;
            S_WB:
                state_next = S_DONE;
            S_DONE:
                if (out_free) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer: input ready and memory and register file port controls
    always_comb
    begin
        s_axis_tready = state_reg == S_IDLE;
        mem_we    = 1'b0;
        mem_waddr = AW'(in_addr);
        mem_wdata = in_byte;
        mem_raddr = pc_reg[AW-1:0] + AW'(cnt_reg[2:0]);
        rf_rsel   = r2;
        unique case (state_reg)
            S_IDLE:
                mem_we = s_hs && in_op == OP_WRITE && wr_item_ok;
            S_LOAD:
                mem_raddr = imm[AW-1:0] + AW'(cnt_reg[2:0]);
            S_STORE:
            begin
                mem_we    = 1'b1;
                mem_waddr = imm[AW-1:0] + AW'(cnt_reg[1:0]);
                mem_wdata = s_reg[8*cnt_reg[1:0] +: 8];
            end
            S_RREAD:
            begin
                priority if (cnt_reg == 6'd0)
                    rf_rsel = r2;
                else if (cnt_reg == 6'd1)
                    rf_rsel = r3;
                else
                    rf_rsel = r1;
            end
            default:
                mem_we = 1'b0;
        endcase
        rf_raddr = (rf_rsel < 8'(NUM_REGS)) ? rf_rsel[RIW-1:0] : '0;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
        if (state_reg == S_WB && wr_reg && r1 != 8'(PC_INDEX))
            rf_mem[r1[RIW-1:0]] <= wb_val;
        rf_rdata_reg <= rf_mem[rf_raddr];
        rf_ridx_reg  <= rf_raddr;
        rf_rpc_reg   <= rf_rsel == 8'(PC_INDEX);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            pc_reg       <= '0;
            halted_reg   <= 1'b1;
            entry_pc_reg <= '0;
            rf_vld_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 6'd0 : cnt_reg + 6'd1;
            if (cfg_wr && paddr == 3'd0)
                entry_pc_reg <= pwdata[16:0];
            if (s_hs && in_op == OP_START)
            begin
                pc_reg     <= 32'(entry_pc_reg);
                halted_reg <= 1'b0;
            end
            if (state_reg == S_FETCH && state_next == S_DECODE)
                pc_reg <= pc_reg + 32'(INSTR_BYTES);
            if (state_reg == S_WB && wr_reg)
            begin
                if (r1 == 8'(PC_INDEX))
                    pc_reg <= wb_val;
                else
                    rf_vld_reg[r1[RIW-1:0]] <= 1'b1;
            end
            if (state_reg == S_DONE && out_free)
            begin
                m_valid_reg <= 1'b1;
                if (status_reg != ST_OK && status_reg != ST_HALTED)
                    halted_reg <= 1'b1;
            end
            else if (m_hs)
                m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                wr_reg     <= 1'b0;
                res_reg    <= '0;
                priority if (s_hs && in_op == OP_STEP && halted_reg)
                    status_reg <= ST_HALTED;
                else if (s_hs && in_op == OP_STEP && !pc_fits)
                    status_reg <= ST_FETCH;
                else
                    status_reg <= ST_OK;
            end
            S_FETCH:
                if (cnt_reg != 6'd0)
                    ins_reg[8*3'(cnt_reg[2:0] - 3'd1) +: 8] <= mem_rdata_reg;
                else
                    nregs_reg <= 2'd0;
            S_DECODE:
            begin
                nregs_reg <= opc_nregs(opc);
                if (!opc_known(opc) || regs_bad)
                    status_reg <= ST_BADOP;
            end
            S_RREAD:
            begin
                if (cnt_reg == 6'd1) a_reg <= (nregs_reg >= 2'd2) ? rd_val : 32'd0;
                if (cnt_reg == 6'd2) b_reg <= (nregs_reg == 2'd3) ? rd_val : 32'd0;
                if (cnt_reg == 6'd3) s_reg <= rd_val;
            end
            S_EXEC:
            begin
                // loads assemble their word from zero
                res_reg  <= (opc == OPC_LDR || opc == OPC_LDB) ? 32'd0 : exec_val;
                dq_reg   <= abs_a;
                dd_reg   <= abs_d;
                drem_reg <= '0;
                dneg_reg <= is_div_exec && (a_reg[31] != dvs[31]);
                priority if (opc == OPC_TRP)
                begin
                    if (imm == 32'd0) status_reg <= ST_TRAP;
                end
                else if (is_div)
                begin
                    if (div_zero) status_reg <= ST_DIVZERO;
                    else wr_reg <= 1'b1;
                end
                else if (opc == OPC_LDR || opc == OPC_LDB)
                begin
                    if ((opc == OPC_LDR) ? word_bad : byte_bad) status_reg <= ST_BADADDR;
                    else wr_reg <= 1'b1;
                end
                else if (opc == OPC_STR || opc == OPC_STB)
                begin
                    if ((opc == OPC_STR) ? word_bad : byte_bad) status_reg <= ST_BADADDR;
                end
                else
                    wr_reg <= 1'b1;
            end
            S_DIV:
            begin
                drem_reg <= ge ? (rem_sh - {1'b0, dd_reg}) : rem_sh;
                dq_reg   <= {dq_reg[30:0], ge};
            end
            S_LOAD:
                if (cnt_reg != 6'd0)
                    res_reg[8*2'(cnt_reg[1:0] - 2'd1) +: 8] <= mem_rdata_reg;
            S_WB:
                res_reg <= wb_val;
            default:
                res_reg <= res_reg;
        endcase
        if (state_reg == S_DONE && out_free)
        begin
            m_user_reg <= status_reg;
            m_data_reg <= {2'b00, wr_reg ? res_reg : 32'd0, wr_reg ? r1[4:0] : 5'd0,
                           wr_reg, (state_reg == S_DONE) ? pc_reg : 32'd0};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr == 3'd0) ? 32'(entry_pc_reg) : 32'd0;

endmodule

/* rtl/tifec_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tifec_checker
    import tifec_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `ASSERT_IMPL(a_nowrite_zero, clk, rst_n, m_axis_tvalid && !m_axis_tdata[32], m_axis_tdata[69:33] == 37'd0)
    `ASSERT_IMPL(a_write_ok, clk, rst_n, m_axis_tvalid && m_axis_tdata[32], m_axis_tuser == ST_OK)

endmodule

bind tiny_isa_fetch_execute_core tifec_checker u_tifec_checker (.*);
